// ----- sv/ffa_pkg.sv -----
// Package for the first-fit free-list allocator: payload and control types,
// codes, sizing constants and the small alignment helpers.
// Depends on nothing; the top level, ffa_ctrl and ffa_dp import it.
`default_nettype none

package ffa_pkg;

  localparam int MAX_EXTENTS_DEF = 16;
  localparam int MAX_RECORDS_DEF = 32;
  localparam int HEADER_BYTES    = 16;
  localparam int POOL_MAX        = 65536;

  typedef enum logic [1:0] {
    FN_ALLOC = 2'd0,
    FN_FREE  = 2'd1,
    FN_CLEAR = 2'd2,
    FN_NOP   = 2'd3
  } ffa_func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNKNOWN = 2'd3
  } ffa_status_t;

  typedef enum logic [1:0] {
    RD_AT     = 2'd0,
    RD_AFTER  = 2'd1,
    RD_BEFORE = 2'd2
  } ffa_rdsel_t;

  typedef enum logic [2:0] {
    WR_RDATA = 3'd0,
    WR_SPLIT = 3'd1,
    WR_PREV  = 3'd2,
    WR_NEXT  = 3'd3,
    WR_NEW   = 3'd4
  } ffa_wrsel_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [16:0] request_bytes;
    logic [7:0]  align_bytes;
    logic [31:0] release_address;
  } ffa_in_t;

  typedef struct packed {
    logic [31:0] granted_address;
    logic [1:0]  status;
    logic [5:0]  live_allocations;
    logic [16:0] bytes_in_use;
  } ffa_out_t;

  typedef struct packed {
    logic [31:0] start;
    logic [16:0] len;
  } ffa_ext_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [7:0]  adj;
    logic [16:0] len;
  } ffa_rec_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic        idle;
    logic        load;
    logic        clear;
    logic        eidx_zero;
    logic        eidx_inc;
    logic        eidx_dec;
    logic        eidx_cnt;
    logic        pos_save;
    logic        ridx_zero;
    logic        ridx_inc;
    logic        ext_rd;
    ffa_rdsel_t  rd_sel;
    logic        ext_wr;
    ffa_wrsel_t  wr_sel;
    logic        cap_cur;
    logic        cap_prev;
    logic        rec_rd;
    logic        alloc_commit;
    logic        free_found;
    logic        free_commit;
    logic        cnt_inc;
    logic        cnt_dec;
    logic        set_status;
    ffa_status_t status;
    logic        emit;
  } ffa_cmd_t;

  // Conditions from the datapath back to the sequencer.
  typedef struct packed {
    logic [1:0] func;
    logic       req_zero;
    logic       eidx_lt_cnt;
    logic       next_lt_cnt;
    logic       eidx_gt_pos;
    logic       fit;
    logic       slot_avail;
    logic       absorb;
    logic       rec_match;
    logic       ridx_last;
    logic       pos_stop;
    logic       mprev;
    logic       mnext;
    logic       cnt_full;
  } ffa_sts_t;

  // Alignment of zero counts as one; otherwise keep the highest set bit.
  function automatic logic [7:0] ffa_align_norm(input logic [7:0] a);
    logic [7:0] r;
    r = 8'd1;
    for (int i = 0; i < 8; i++) begin
      if (a[i]) r = 8'(8'd1 << i);
    end
    return r;
  endfunction

  // Forward adjustment that aligns the address and leaves a header in front.
  function automatic logic [7:0] ffa_adjust(input logic [7:0] addr_lo, input logic [7:0] a);
    logic [7:0] m;
    logic [7:0] adj;
    logic [7:0] need;
    logic [7:0] up;
    m    = a - 8'd1;
    adj  = (8'd0 - addr_lo) & m;
    need = 8'(HEADER_BYTES) - adj;
    up   = (need + m) & ~m;
    if (adj < 8'(HEADER_BYTES)) adj = adj + up;
    return adj;
  endfunction

endpackage

`default_nettype wire

// ----- sv/first_fit_free_list_allocator_unit.sv -----
// Top level of the first-fit free-list allocator: configuration registers,
// result register and the sequencer and datapath. Depends on ffa_pkg,
// ffa_ctrl, ffa_dp and ffa_ram.
//
// Usage. An input transaction on in_valid/in_stall/in_data carries an
// operation: allocate, free, clear the pool, or no operation. Every input
// transaction produces exactly one result transaction on out_valid/out_stall/
// out_data with the granted address, a status code and the live allocation
// count and byte total after the operation.
// Items are processed one at a time. An allocate examines extents in order
// until one fits and, when an extent is used up, shifts the later entries
// down; a free searches the records, walks the extents to the insertion point
// and shifts entries to make room for a new extent or to close up a merged
// one. A clear or a no operation walks no table. in_stall is low only
// while the sequencer is idle, including while a finished result still sits
// stalled in the output register; a following result waits in the sequencer
// until that register is taken.
// After reset the block loads the pool as a single extent
// from the reset values of pool_base and pool_length before taking items.
// pool_base and pool_length must be written over the APB port only while idle;
// the block does not enforce this. pool_length takes effect on the next clear.
`default_nettype none

module first_fit_free_list_allocator_unit import ffa_pkg::*; #(
  parameter int MAX_EXTENTS = MAX_EXTENTS_DEF,
  parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire ffa_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output ffa_out_t         out_data,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam logic REG_POOL_BASE   = 1'b0;
  localparam logic REG_POOL_LENGTH = 1'b1;

  logic [31:0] pool_base_r;
  logic [16:0] pool_length_r;
  logic        cfg_wr;

  ffa_cmd_t cmd;
  ffa_sts_t sts;
  ffa_out_t result;

  logic     out_valid_r;
  ffa_out_t out_data_r;
  logic     out_busy;

  // The APB port never waits; a write lands in the access phase.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r   <= '0;
      pool_length_r <= 17'(POOL_MAX);
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_POOL_LENGTH) begin
        pool_length_r <= cfg_pwdata[16:0];
      end else begin
        pool_base_r <= cfg_pwdata;
      end
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_POOL_BASE) ? pool_base_r : {15'd0, pool_length_r};

  // The output register holds one result; the sequencer waits for it only
  // when it is both full and stalled.
  assign out_busy = out_valid_r && out_stall;

  ffa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_busy (out_busy),
    .sts      (sts),
    .cmd      (cmd)
  );

  ffa_dp #(.MAX_EXTENTS(MAX_EXTENTS), .MAX_RECORDS(MAX_RECORDS)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_data     (in_data),
    .pool_base   (pool_base_r),
    .pool_length (pool_length_r),
    .sts         (sts),
    .result      (result)
  );

  assign in_stall = !cmd.idle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) out_data_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- sv/ffa_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read.
// Used for the extent table and the allocation records; no dependencies.
`default_nettype none

module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- sv/ffa_ctrl.sv -----
// Sequencer of the allocator: walks extents and records one entry at a time
// and drives the datapath through ffa_cmd_t. Depends on ffa_pkg.
`default_nettype none

module ffa_ctrl import ffa_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     out_busy,
  input  wire ffa_sts_t sts,
  output ffa_cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DISP,
    S_A_RD, S_A_EV, S_A_CHK,
    S_RM_RD, S_RM_EV,
    S_F_RD, S_F_EV,
    S_P_RD, S_P_EV, S_P_CHK, S_MERGE,
    S_I_RD, S_I_EV,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        cmd.clear = 1'b1;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cmd.idle = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.func)
          FN_ALLOC: begin
            if (sts.req_zero) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_NOFIT;
              state_nxt      = S_DONE;
            end else begin
              cmd.eidx_zero = 1'b1;
              state_nxt     = S_A_RD;
            end
          end
          FN_FREE: begin
            cmd.ridx_zero = 1'b1;
            state_nxt     = S_F_RD;
          end
          FN_CLEAR: begin
            cmd.clear = 1'b1;
            state_nxt = S_DONE;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_A_RD: begin
        if (sts.eidx_lt_cnt) begin
          cmd.ext_rd = 1'b1;
          cmd.rd_sel = RD_AT;
          state_nxt  = S_A_EV;
        end else begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_NOFIT;
          state_nxt      = S_DONE;
        end
      end
      S_A_EV: begin
        cmd.cap_cur = 1'b1;
        state_nxt   = S_A_CHK;
      end
      S_A_CHK: begin
        if (!sts.fit) begin
          cmd.eidx_inc = 1'b1;
          state_nxt    = S_A_RD;
        end else if (!sts.slot_avail) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_FULL;
          state_nxt      = S_DONE;
        end else begin
          cmd.alloc_commit = 1'b1;
          if (sts.absorb) begin
            state_nxt = S_RM_RD;
          end else begin
            cmd.ext_wr = 1'b1;
            cmd.wr_sel = WR_SPLIT;
            state_nxt  = S_DONE;
          end
        end
      end
      S_RM_RD: begin
        if (sts.next_lt_cnt) begin
          cmd.ext_rd = 1'b1;
          cmd.rd_sel = RD_AFTER;
          state_nxt  = S_RM_EV;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_RM_EV: begin
        cmd.ext_wr   = 1'b1;
        cmd.wr_sel   = WR_RDATA;
        cmd.eidx_inc = 1'b1;
        state_nxt    = S_RM_RD;
      end
      S_F_RD: begin
        cmd.rec_rd = 1'b1;
        state_nxt  = S_F_EV;
      end
      S_F_EV: begin
        if (sts.rec_match) begin
          cmd.free_found = 1'b1;
          cmd.eidx_zero  = 1'b1;
          state_nxt      = S_P_RD;
        end else if (sts.ridx_last) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_UNKNOWN;
          state_nxt      = S_DONE;
        end else begin
          cmd.ridx_inc = 1'b1;
          state_nxt    = S_F_RD;
        end
      end
      S_P_RD: begin
        if (sts.eidx_lt_cnt) begin
          cmd.ext_rd = 1'b1;
          cmd.rd_sel = RD_AT;
          state_nxt  = S_P_EV;
        end else begin
          state_nxt = S_MERGE;
        end
      end
      S_P_EV: begin
        cmd.cap_cur = 1'b1;
        state_nxt   = S_P_CHK;
      end
      S_P_CHK: begin
        if (sts.pos_stop) begin
          state_nxt = S_MERGE;
        end else begin
          cmd.cap_prev = 1'b1;
          cmd.eidx_inc = 1'b1;
          state_nxt    = S_P_RD;
        end
      end
      S_MERGE: begin
        if (sts.mprev) begin
          cmd.ext_wr      = 1'b1;
          cmd.wr_sel      = WR_PREV;
          cmd.free_commit = 1'b1;
          state_nxt       = sts.mnext ? S_RM_RD : S_DONE;
        end else if (sts.mnext) begin
          cmd.ext_wr      = 1'b1;
          cmd.wr_sel      = WR_NEXT;
          cmd.free_commit = 1'b1;
          state_nxt       = S_DONE;
        end else if (sts.cnt_full) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_FULL;
          state_nxt      = S_DONE;
        end else begin
          cmd.free_commit = 1'b1;
          cmd.pos_save    = 1'b1;
          cmd.eidx_cnt    = 1'b1;
          state_nxt       = S_I_RD;
        end
      end
      S_I_RD: begin
        if (sts.eidx_gt_pos) begin
          cmd.ext_rd = 1'b1;
          cmd.rd_sel = RD_BEFORE;
          state_nxt  = S_I_EV;
        end else begin
          cmd.ext_wr  = 1'b1;
          cmd.wr_sel  = WR_NEW;
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_I_EV: begin
        cmd.ext_wr   = 1'b1;
        cmd.wr_sel   = WR_RDATA;
        cmd.eidx_dec = 1'b1;
        state_nxt    = S_I_RD;
      end
      S_DONE: begin
        if (!out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/ffa_dp.sv -----
// Datapath of the allocator: extent table and record RAMs, record valid bits,
// counters, tallies and the fit and merge arithmetic. Depends on ffa_pkg, ffa_ram.
`default_nettype none

module ffa_dp import ffa_pkg::*; #(
  parameter int MAX_EXTENTS = MAX_EXTENTS_DEF,
  parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire ffa_cmd_t    cmd,
  input  wire ffa_in_t     in_data,
  input  wire logic [31:0] pool_base,
  input  wire logic [16:0] pool_length,
  output ffa_sts_t         sts,
  output ffa_out_t         result
);

  localparam int EIDX_W  = $clog2(MAX_EXTENTS);
  localparam int ECNT_W  = $clog2(MAX_EXTENTS + 1);
  localparam int RIDX_W  = $clog2(MAX_RECORDS);
  localparam int TALLY_W = $clog2(MAX_RECORDS + 1);

  logic [1:0]        fn_r;
  logic [16:0]       req_r;
  logic [7:0]        a_r;
  logic [31:0]       rel_r;
  logic [31:0]       base_r;
  logic [ECNT_W-1:0] cnt_r;
  logic [ECNT_W-1:0] eidx_r;
  logic [ECNT_W-1:0] pos_r;
  logic [RIDX_W-1:0] ridx_r;
  logic [RIDX_W-1:0] k_r;
  ffa_ext_t          cur_r;
  ffa_ext_t          prev_r;
  logic [31:0]       bstart_r;
  logic [16:0]       blen_r;
  logic [31:0]       granted_r;
  ffa_status_t       status_r;
  logic [MAX_RECORDS-1:0] valid_r;
  logic [TALLY_W-1:0] tally_r;
  logic [16:0]       used_r;

  logic [ECNT_W-1:0] eidx_p1, eidx_m1;
  logic [7:0]        adj;
  logic [17:0]       total;
  logic [16:0]       left;
  logic [16:0]       rec_len;
  logic [31:0]       grant;
  logic [RIDX_W-1:0] slot;
  logic              slot_avail;
  logic [16:0]       len_cap;
  logic [31:0]       boff;
  logic              mprev, mnext;

  logic              ext_we;
  logic [EIDX_W-1:0] ext_waddr, ext_raddr;
  ffa_ext_t          ext_wdata, ext_rdata;
  ffa_rec_t          rec_wdata, rec_rdata;

  assign eidx_p1 = eidx_r + 1'b1;
  assign eidx_m1 = eidx_r - 1'b1;

  // Fit test of the current extent.
  assign adj     = ffa_adjust(cur_r.start[7:0], a_r);
  assign total   = {1'b0, req_r} + {10'd0, adj};
  assign left    = cur_r.len - total[16:0];
  assign rec_len = sts.absorb ? cur_r.len : total[16:0];
  assign grant   = cur_r.start + {24'd0, adj};
  assign len_cap = ({15'd0, pool_length} > 32'(POOL_MAX)) ? 17'(POOL_MAX) : pool_length;

  // Merge conditions while freeing.
  assign boff  = bstart_r - base_r;
  assign mprev = (eidx_r != '0) && (prev_r.start + {15'd0, prev_r.len} == bstart_r);
  assign mnext = (eidx_r < cnt_r) && (bstart_r + {15'd0, blen_r} == cur_r.start);

  always_comb begin
    slot       = '0;
    slot_avail = 1'b0;
    for (int i = MAX_RECORDS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        slot       = RIDX_W'(i);
        slot_avail = 1'b1;
      end
    end
  end

  always_comb begin
    sts.func        = fn_r;
    sts.req_zero    = (req_r == '0);
    sts.eidx_lt_cnt = (eidx_r < cnt_r);
    sts.next_lt_cnt = ({1'b0, eidx_r} + 1'b1) < {1'b0, cnt_r};
    sts.eidx_gt_pos = (eidx_r > pos_r);
    sts.fit         = ({1'b0, cur_r.len} >= total);
    sts.slot_avail  = slot_avail;
    sts.absorb      = (left <= 17'(HEADER_BYTES + 1));
    sts.rec_match   = valid_r[ridx_r] && (rec_rdata.addr == rel_r);
    sts.ridx_last   = (ridx_r == RIDX_W'(MAX_RECORDS - 1));
    sts.pos_stop    = ((cur_r.start - base_r) > boff);
    sts.mprev       = mprev;
    sts.mnext       = mnext;
    sts.cnt_full    = (cnt_r >= ECNT_W'(MAX_EXTENTS));
  end

  always_comb begin
    ext_we    = cmd.ext_wr || cmd.clear;
    ext_waddr = eidx_r[EIDX_W-1:0];
    ext_wdata = cur_r;
    if (cmd.clear) begin
      ext_waddr = '0;
      ext_wdata = '{start: pool_base, len: len_cap};
    end else begin
      case (cmd.wr_sel)
        WR_RDATA: ext_wdata = ext_rdata;
        WR_SPLIT: ext_wdata = '{start: cur_r.start + {14'd0, total}, len: left};
        WR_PREV: begin
          ext_waddr = eidx_m1[EIDX_W-1:0];
          ext_wdata = '{start: prev_r.start,
                        len: prev_r.len + blen_r + (mnext ? cur_r.len : 17'd0)};
        end
        WR_NEXT: ext_wdata = '{start: bstart_r, len: cur_r.len + blen_r};
        WR_NEW:  ext_wdata = '{start: bstart_r, len: blen_r};
        default: ext_wdata = cur_r;
      endcase
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_AFTER:  ext_raddr = eidx_p1[EIDX_W-1:0];
      RD_BEFORE: ext_raddr = eidx_m1[EIDX_W-1:0];
      default:   ext_raddr = eidx_r[EIDX_W-1:0];
    endcase
  end

  assign rec_wdata = '{addr: grant, adj: adj, len: rec_len};

  ffa_ram #(.WIDTH($bits(ffa_ext_t)), .DEPTH(MAX_EXTENTS)) u_ext_ram (
    .clk   (clk),
    .we    (ext_we),
    .waddr (ext_waddr),
    .wdata (ext_wdata),
    .re    (cmd.ext_rd),
    .raddr (ext_raddr),
    .rdata (ext_rdata)
  );

  ffa_ram #(.WIDTH($bits(ffa_rec_t)), .DEPTH(MAX_RECORDS)) u_rec_ram (
    .clk   (clk),
    .we    (cmd.alloc_commit),
    .waddr (slot),
    .wdata (rec_wdata),
    .re    (cmd.rec_rd),
    .raddr (ridx_r),
    .rdata (rec_rdata)
  );

  // Pool bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      valid_r <= '0;
      tally_r <= '0;
      used_r  <= '0;
    end else if (cmd.clear) begin
      cnt_r   <= (len_cap == '0) ? '0 : ECNT_W'(1);
      valid_r <= '0;
      tally_r <= '0;
      used_r  <= '0;
    end else begin
      if (cmd.cnt_inc) cnt_r <= cnt_r + 1'b1;
      if (cmd.cnt_dec && cnt_r != '0) cnt_r <= cnt_r - 1'b1;
      if (cmd.alloc_commit) begin
        valid_r[slot] <= 1'b1;
        tally_r       <= tally_r + 1'b1;
        used_r        <= used_r + rec_len;
      end
      if (cmd.free_commit) begin
        valid_r[k_r] <= 1'b0;
        if (tally_r != '0) tally_r <= tally_r - 1'b1;
        used_r <= (used_r >= blen_r) ? used_r - blen_r : 17'd0;
      end
    end
  end

  // Operands, walk indexes and per-transaction results.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fn_r      <= in_data.func;
      req_r     <= in_data.request_bytes;
      a_r       <= ffa_align_norm(in_data.align_bytes);
      rel_r     <= in_data.release_address;
      granted_r <= '0;
      status_r  <= ST_OK;
    end
    if (cmd.set_status) status_r <= cmd.status;
    if (cmd.alloc_commit) granted_r <= grant;
    if (cmd.clear) base_r <= pool_base;

    if (cmd.eidx_zero) eidx_r <= '0;
    if (cmd.eidx_inc)  eidx_r <= eidx_p1;
    if (cmd.eidx_dec)  eidx_r <= eidx_m1;
    if (cmd.eidx_cnt)  eidx_r <= cnt_r;
    if (cmd.pos_save)  pos_r  <= eidx_r;
    if (cmd.ridx_zero) ridx_r <= '0;
    if (cmd.ridx_inc)  ridx_r <= ridx_r + 1'b1;

    if (cmd.cap_cur)  cur_r  <= ext_rdata;
    if (cmd.cap_prev) prev_r <= cur_r;
    if (cmd.free_found) begin
      k_r      <= ridx_r;
      bstart_r <= rel_r - {24'd0, rec_rdata.adj};
      blen_r   <= rec_rdata.len;
    end
  end

  assign result.granted_address  = granted_r;
  assign result.status           = status_r;
  assign result.live_allocations = 6'(tally_r);
  assign result.bytes_in_use     = used_r;

endmodule

`default_nettype wire
